@@ rtl/gmfps_pkg.sv @@
`timescale 1ns / 1ps

package gmfps_pkg;

  localparam int ELEM_W = 16;
  localparam int COST_W = 27;
  localparam int DIM_W  = 11;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam int IN_DW  = 16;
  localparam int OUT_DW = 32;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  // largest positive cost, start value of the bottom-row minimum
  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};

  typedef enum logic [0:0] {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } reg_idx_t;

endpackage

@@ rtl/gmfps_row_mem.sv @@
`timescale 1ns / 1ps

module gmfps_row_mem #(
  parameter int DEPTH = gmfps_pkg::DEF_MAX_COLS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [AW-1:0]                         wr_addr,
  input  logic signed [gmfps_pkg::COST_W-1:0]   wr_data,
  input  logic                                  rd_en,
  input  logic [AW-1:0]                         rd_addr_a,
  input  logic [AW-1:0]                         rd_addr_b,
  output logic signed [gmfps_pkg::COST_W-1:0]   rd_data_a,
  output logic signed [gmfps_pkg::COST_W-1:0]   rd_data_b
);

  logic signed [gmfps_pkg::COST_W-1:0] mem [DEPTH];
  logic signed [gmfps_pkg::COST_W-1:0] rd_a_r;
  logic signed [gmfps_pkg::COST_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the old contents when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

@@ rtl/gmfps_cfg_regs.sv @@
`timescale 1ns / 1ps

module gmfps_cfg_regs #(
  parameter int MAX_COLS = gmfps_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gmfps_pkg::DEF_MAX_ROWS,
  parameter int CCNT_W   = ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1) + 1,
  parameter int RCNT_W   = ((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1) + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [gmfps_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [gmfps_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [gmfps_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                         cfg_pready,
  output logic [CCNT_W-1:0]            cols_eff,
  output logic [RCNT_W-1:0]            rows_eff,
  output logic                         restart
);

  logic [gmfps_pkg::DIM_W-1:0] cols_r;
  logic [gmfps_pkg::DIM_W-1:0] rows_r;
  logic                        wr_go;
  gmfps_pkg::reg_idx_t         idx;
  logic [31:0]                 cols_ext;
  logic [31:0]                 rows_ext;
  logic [31:0]                 cols_clamp;
  logic [31:0]                 rows_clamp;

  assign cfg_pready = 1'b1;
  assign idx        = gmfps_pkg::reg_idx_t'(cfg_paddr[2]);
  assign wr_go      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= gmfps_pkg::DIM_W'(1);
      rows_r <= gmfps_pkg::DIM_W'(1);
    end else if (wr_go) begin
      unique case (idx)
        gmfps_pkg::REG_GRID_COLS: cols_r <= cfg_pwdata[gmfps_pkg::DIM_W-1:0];
        gmfps_pkg::REG_GRID_ROWS: rows_r <= cfg_pwdata[gmfps_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // any register write abandons the grid in progress
  assign restart = wr_go;

  always_comb begin
    unique case (idx)
      gmfps_pkg::REG_GRID_COLS: cfg_prdata = gmfps_pkg::CFG_DW'(cols_r);
      gmfps_pkg::REG_GRID_ROWS: cfg_prdata = gmfps_pkg::CFG_DW'(rows_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // zero acts as one, anything above the bound acts as the bound
  assign cols_ext   = 32'(cols_r);
  assign rows_ext   = 32'(rows_r);
  assign cols_clamp = (cols_ext == 32'd0) ? 32'd1 :
                      (cols_ext > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cols_ext;
  assign rows_clamp = (rows_ext == 32'd0) ? 32'd1 :
                      (rows_ext > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : rows_ext;
  assign cols_eff   = cols_clamp[CCNT_W-1:0];
  assign rows_eff   = rows_clamp[RCNT_W-1:0];

endmodule

@@ rtl/grid_min_falling_path_sum.sv @@
`timescale 1ns / 1ps

// Minimum falling path sum over a streamed grid.
// Grid elements (signed 16 bit) enter on the in_ stream in row-major order,
// one word per cycle when not stalled. After the last element of a grid
// one word leaves on the out_ stream: the least path cost, signed 27 bit.
// Grid size is set over the cfg_ APB port: grid_cols at 0x0, grid_rows at
// 0x4; zero acts as one, values above MAX_COLS / MAX_ROWS act as the bound.
// A register write restarts the grid; the user must do it only while the
// block idles, the block does not enforce it. Throughput: one element per
// cycle unless a held result stalls the last element. The accept cycle
// reads the row store at its own and its right-hand column, the cost stage
// then adds the element to the least of the costs above and writes the new
// cost back; the result is registered as the last element leaves that stage.
// Reset sets both dimensions to one and starts a new grid; the row store
// needs no clearing, the first row ignores what it reads.
// When out_tready is low the result word holds; the next grid keeps
// streaming until its own last element has to wait behind it.
module grid_min_falling_path_sum #(
  parameter int MAX_COLS = gmfps_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gmfps_pkg::DEF_MAX_ROWS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [gmfps_pkg::IN_DW-1:0]  in_tdata,   // [15:0] element_value
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [gmfps_pkg::OUT_DW-1:0] out_tdata,  // [26:0] min_path_sum, zero fill above
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [gmfps_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [gmfps_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [gmfps_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                         cfg_pready
);

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCNT_W = COL_W + 1;
  localparam int RCNT_W = ROW_W + 1;
  localparam int CW     = gmfps_pkg::COST_W;

  logic [CCNT_W-1:0] cols_eff;
  logic [RCNT_W-1:0] rows_eff;
  logic              restart;

  gmfps_cfg_regs #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CCNT_W   (CCNT_W),
    .RCNT_W   (RCNT_W)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cols_eff    (cols_eff),
    .rows_eff    (rows_eff),
    .restart     (restart)
  );

  // ---------------- accept stage: position counters and row store read
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CCNT_W-1:0] col_inc;
  logic [RCNT_W-1:0] row_inc;
  logic              last_col, last_row;
  logic [COL_W-1:0]  right_addr;
  logic              in_fire;

  assign col_inc    = {1'b0, col_r} + CCNT_W'(1);
  assign row_inc    = {1'b0, row_r} + RCNT_W'(1);
  assign last_col   = (col_inc == cols_eff);
  assign last_row   = (row_inc == rows_eff);
  assign right_addr = col_inc[COL_W-1:0];
  assign in_fire    = in_tvalid & in_tready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- cost stage
  logic                     s2_valid_r;
  logic signed [gmfps_pkg::ELEM_W-1:0] s2_elem_r;
  logic [COL_W-1:0]         s2_col_r;
  logic                     s2_first_row_r;
  logic                     s2_last_row_r;
  logic                     s2_has_left_r;
  logic                     s2_has_right_r;
  logic                     s2_last_item_r;
  logic                     s2_fire;

  logic signed [CW-1:0] rd_cur, rd_right;
  logic signed [CW-1:0] up_cur, up_right, best, cost;
  logic signed [CW-1:0] held_r;
  logic signed [CW-1:0] bmin_r;
  logic signed [CW-1:0] final_min;

  logic                 fwd_cur_r, fwd_right_r;
  logic signed [CW-1:0] fwd_data_r;

  logic                 out_valid_r;
  logic [CW-1:0]        out_data_r;

  assign s2_fire   = s2_valid_r & ~(s2_last_item_r & out_valid_r & ~out_tready);
  assign in_tready = ~s2_valid_r | s2_fire;

  gmfps_row_mem #(
    .DEPTH (MAX_COLS),
    .AW    (COL_W)
  ) u_row_mem (
    .clk       (clk),
    .wr_en     (s2_fire),
    .wr_addr   (s2_col_r),
    .wr_data   (cost),
    .rd_en     (in_fire),
    .rd_addr_a (col_r),
    .rd_addr_b (right_addr),
    .rd_data_a (rd_cur),
    .rd_data_b (rd_right)
  );

  // forward the cost written in the read cycle, the store returns old data
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_cur_r   <= s2_fire && (s2_col_r == col_r);
      fwd_right_r <= s2_fire && (s2_col_r == right_addr);
      fwd_data_r  <= cost;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_fire) begin
      s2_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_elem_r      <= in_tdata[gmfps_pkg::ELEM_W-1:0];
      s2_col_r       <= col_r;
      s2_first_row_r <= (row_r == '0);
      s2_last_row_r  <= last_row;
      s2_has_left_r  <= (col_r != '0);
      s2_has_right_r <= ~last_col;
      s2_last_item_r <= last_col & last_row;
    end
  end

  assign up_cur   = fwd_cur_r   ? fwd_data_r : rd_cur;
  assign up_right = fwd_right_r ? fwd_data_r : rd_right;

  always_comb begin
    best = up_cur;
    if (s2_has_left_r && (held_r < best)) begin
      best = held_r;
    end
    if (s2_has_right_r && (up_right < best)) begin
      best = up_right;
    end
    if (s2_first_row_r) begin
      cost = CW'(s2_elem_r);
    end else begin
      cost = CW'(s2_elem_r) + best;
    end
  end

  assign final_min = (s2_last_row_r && (cost < bmin_r)) ? cost : bmin_r;

  // held_r keeps the old cost above the column to the left
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      held_r <= '0;
      bmin_r <= gmfps_pkg::COST_MAX;
    end else if (s2_fire) begin
      held_r <= s2_has_right_r ? up_cur : '0;
      bmin_r <= s2_last_item_r ? gmfps_pkg::COST_MAX : final_min;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire && s2_last_item_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_last_item_r) begin
      out_data_r <= final_min;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = gmfps_pkg::OUT_DW'(out_data_r);

endmodule
